@@ rtl/dpalu_pkg.sv @@
package dpalu_pkg;

	// Data-processing opcodes, instruction bits 24-21
	localparam logic [3:0] OPC_AND = 4'd0;
	localparam logic [3:0] OPC_EOR = 4'd1;
	localparam logic [3:0] OPC_SUB = 4'd2;
	localparam logic [3:0] OPC_RSB = 4'd3;
	localparam logic [3:0] OPC_ADD = 4'd4;
	localparam logic [3:0] OPC_ADC = 4'd5;
	localparam logic [3:0] OPC_SBC = 4'd6;
	localparam logic [3:0] OPC_RSC = 4'd7;
	localparam logic [3:0] OPC_ORR = 4'd12;
	localparam logic [3:0] OPC_BIC = 4'd14;

	// Form codes, instruction bits 27-25
	localparam logic [2:0] FORM_REG = 3'd0;
	localparam logic [2:0] FORM_IMM = 3'd1;

	// Shift types, register form bits 6-5
	localparam logic [1:0] SHT_LSL = 2'd0;
	localparam logic [1:0] SHT_LSR = 2'd1;
	localparam logic [1:0] SHT_ASR = 2'd2;
	localparam logic [1:0] SHT_ROR = 2'd3;

	localparam logic [3:0] REG_PC = 4'd15;

	// Incoming word
	typedef struct packed {
		logic        cin;
		logic [31:0] rm_val;
		logic [31:0] rn_val;
		logic [31:0] instr;
	} in_t;

	// Decoded control carried down the pipe
	typedef struct packed {
		logic       ok;
		logic       logical;
		logic       s;
		logic [3:0] rd;
		logic [3:0] opc;
	} ctrl_t;

	// After decode and shifter
	typedef struct packed {
		ctrl_t       ctrl;
		logic [31:0] rn_val;
		logic [31:0] right;
		logic        shc;
		logic        cin;
	} dec_t;

	// After adder / logic unit
	typedef struct packed {
		ctrl_t       ctrl;
		logic [31:0] res;
		logic        c;
		logic        v;
	} exe_t;

	// Final result, packed order matches the output word
	typedef struct packed {
		logic        flag_v;
		logic        write_overflow;
		logic        flag_c;
		logic        flag_z;
		logic        flag_n;
		logic        write_flags;
		logic [31:0] result_value;
		logic [3:0]  dest_reg;
		logic        accepted;
	} res_t;

endpackage

@@ rtl/dpalu_shift.sv @@
module dpalu_shift (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dpalu_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dpalu_pkg::dec_t  out_data
);

	logic            valid_s1;
	dpalu_pkg::dec_t data_s1;
	dpalu_pkg::dec_t nxt;

	logic [2:0]  form;
	logic [3:0]  opc;
	logic [4:0]  imm5;
	logic [1:0]  sht;
	logic [5:0]  n;
	logic [32:0] wide;
	logic [32:0] sx;
	logic [63:0] dbl;
	logic [31:0] imm8;
	logic [4:0]  rot;
	logic        form_ok;
	logic        sup;

	// Decode and shifter operand
	always_comb begin
		form    = in_data.instr[27:25];
		opc     = in_data.instr[24:21];
		imm5    = in_data.instr[11:7];
		sht     = in_data.instr[6:5];
		n       = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
		wide    = '0;
		sx      = '0;
		dbl     = '0;
		imm8    = {24'd0, in_data.instr[7:0]};
		rot     = {in_data.instr[11:8], 1'b0};
		form_ok = ((form == dpalu_pkg::FORM_REG) && !in_data.instr[4]
			&& (in_data.instr[3:0] != dpalu_pkg::REG_PC))
			|| (form == dpalu_pkg::FORM_IMM);
		sup     = opc inside {[dpalu_pkg::OPC_AND:dpalu_pkg::OPC_RSC], dpalu_pkg::OPC_ORR,
			dpalu_pkg::OPC_BIC};

		nxt.ctrl.ok      = form_ok && sup && (in_data.instr[19:16] != dpalu_pkg::REG_PC)
			&& !((in_data.instr[15:12] == dpalu_pkg::REG_PC) && in_data.instr[20]);
		nxt.ctrl.logical = (opc == dpalu_pkg::OPC_AND) || (opc == dpalu_pkg::OPC_EOR)
			|| (opc == dpalu_pkg::OPC_ORR) || (opc == dpalu_pkg::OPC_BIC);
		nxt.ctrl.s       = in_data.instr[20];
		nxt.ctrl.rd      = in_data.instr[15:12];
		nxt.ctrl.opc     = opc;
		nxt.rn_val       = in_data.rn_val;
		nxt.cin          = in_data.cin;
		nxt.right        = in_data.rm_val;
		nxt.shc          = in_data.cin;

		if (form == dpalu_pkg::FORM_IMM) begin
			// rotated 8-bit immediate
			dbl = {imm8, imm8} >> rot;
			nxt.right = dbl[31:0];
			if (rot != 5'd0) begin
				nxt.shc = dbl[31];
			end
		end else begin
			case (sht)
				dpalu_pkg::SHT_LSL: begin
					wide = {1'b0, in_data.rm_val} << imm5;
					nxt.right = wide[31:0];
					if (imm5 != 5'd0) begin
						nxt.shc = wide[32];
					end
				end
				dpalu_pkg::SHT_LSR: begin
					wide = {in_data.rm_val, 1'b0} >> n;
					nxt.right = wide[32:1];
					nxt.shc   = wide[0];
				end
				dpalu_pkg::SHT_ASR: begin
					sx = $signed({in_data.rm_val, 1'b0}) >>> n;
					nxt.right = sx[32:1];
					nxt.shc   = sx[0];
				end
				default: begin
					if (imm5 == 5'd0) begin
						// RRX
						nxt.right = {in_data.cin, in_data.rm_val[31:1]};
						nxt.shc   = in_data.rm_val[0];
					end else begin
						dbl = {in_data.rm_val, in_data.rm_val} >> imm5;
						nxt.right = dbl[31:0];
						nxt.shc   = dbl[31];
					end
				end
			endcase
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

@@ rtl/dpalu_exec.sv @@
module dpalu_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dpalu_pkg::dec_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dpalu_pkg::exe_t  out_data
);

	logic            valid_s2;
	dpalu_pkg::exe_t data_s2;
	dpalu_pkg::exe_t nxt;

	logic [31:0] a;
	logic [31:0] b;
	logic        ci;
	logic [32:0] sum;
	logic        add_v;

	// Adder with operand inversion, plus logic unit
	always_comb begin
		a  = in_data.rn_val;
		b  = in_data.right;
		ci = in_data.cin;
		case (in_data.ctrl.opc)
			dpalu_pkg::OPC_SUB: begin
				b  = ~in_data.right;
				ci = 1'b1;
			end
			dpalu_pkg::OPC_RSB: begin
				a  = ~in_data.rn_val;
				ci = 1'b1;
			end
			dpalu_pkg::OPC_ADD: ci = 1'b0;
			dpalu_pkg::OPC_SBC: b  = ~in_data.right;
			dpalu_pkg::OPC_RSC: a  = ~in_data.rn_val;
			default: ;
		endcase
		sum   = {1'b0, a} + {1'b0, b} + {32'd0, ci};
		add_v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);

		nxt.ctrl = in_data.ctrl;
		nxt.res  = sum[31:0];
		nxt.c    = sum[32];
		nxt.v    = add_v;
		case (in_data.ctrl.opc)
			dpalu_pkg::OPC_AND: nxt.res = in_data.rn_val & in_data.right;
			dpalu_pkg::OPC_EOR: nxt.res = in_data.rn_val ^ in_data.right;
			dpalu_pkg::OPC_ORR: nxt.res = in_data.rn_val | in_data.right;
			dpalu_pkg::OPC_BIC: nxt.res = in_data.rn_val & ~in_data.right;
			default: ;
		endcase
		if (in_data.ctrl.logical) begin
			nxt.c = in_data.shc;
			nxt.v = 1'b0;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

@@ rtl/dpalu_flags.sv @@
module dpalu_flags (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dpalu_pkg::exe_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output dpalu_pkg::res_t  out_data
);

	logic            valid_s3;
	dpalu_pkg::res_t data_s3;
	dpalu_pkg::res_t nxt;

	// Flags, write enables; rejected words give all zeros
	always_comb begin
		nxt = '0;
		if (in_data.ctrl.ok) begin
			nxt.accepted       = 1'b1;
			nxt.dest_reg       = in_data.ctrl.rd;
			nxt.result_value   = in_data.res;
			nxt.write_flags    = in_data.ctrl.s;
			nxt.flag_n         = in_data.res[31];
			nxt.flag_z         = (in_data.res == 32'd0);
			nxt.flag_c         = in_data.c;
			nxt.write_overflow = in_data.ctrl.s && !in_data.ctrl.logical;
			nxt.flag_v         = in_data.v;
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

@@ rtl/arm_data_processing_alu.sv @@
// Channel | Dir | Signals                  | Word
// s_axis  | in  | s_tvalid s_tready s_tdata | 104 bits, instruction, operands, carry
// m_axis  | out | m_tvalid m_tready m_tdata | 48 bits, result and flags
//
// Three register stages: decode/shifter, adder/logic, flags/output register.
// One word is taken per cycle, rate 1, while m_tready does not stall the pipe.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds its word while the next one is full and stalled, so
// back-pressure ripples upstream without loss or repeat.
module arm_data_processing_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] instruction_word, [63:32] first_operand, [95:64] second_operand,
	// [96] carry_flag_in, [103:97] zero
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] accepted, [4:1] dest_reg, [36:5] result_value, [37] write_flags,
	// [38] flag_n, [39] flag_z, [40] flag_c, [41] write_overflow, [42] flag_v,
	// [47:43] zero
	output logic [47:0]  m_tdata
);

	dpalu_pkg::in_t  in_word;
	dpalu_pkg::dec_t dec_data;
	dpalu_pkg::exe_t exe_data;
	dpalu_pkg::res_t res_data;
	logic            dec_valid;
	logic            dec_ready;
	logic            exe_valid;
	logic            exe_ready;

	assign in_word.instr  = s_tdata[31:0];
	assign in_word.rn_val = s_tdata[63:32];
	assign in_word.rm_val = s_tdata[95:64];
	assign in_word.cin    = s_tdata[96];

	dpalu_shift u_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (in_word),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_data  (dec_data)
	);

	dpalu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (exe_valid),
		.out_ready (exe_ready),
		.out_data  (exe_data)
	);

	dpalu_flags u_flags (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exe_valid),
		.in_ready  (exe_ready),
		.in_data   (exe_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_data)
	);

	assign m_tdata = {5'd0, res_data};

	// A rejected word carries nothing else
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_data.accepted) |-> (m_tdata == 48'd0))
		else $error("rejected word has nonzero fields");

	// V enable implies the flag enable of an accepted word
	a_wov_implies_wf: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_data.write_overflow) |-> (res_data.write_flags && res_data.accepted))
		else $error("write_overflow without write_flags");

	// Z flag agrees with the result
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_data.accepted) |->
			(res_data.flag_z == (res_data.result_value == 32'd0)))
		else $error("flag_z disagrees with result");

	// A full pipe under stall refuses new words
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && exe_valid && dec_valid) |-> !s_tready)
		else $error("input taken while pipe is full and stalled");

endmodule
